FILE: rtl/script_lexer_tokenizer_core_defines.svh
// Assertion macros shared by the lexer modules.
`ifndef SCRIPT_LEXER_TOKENIZER_CORE_DEFINES_SVH
`define SCRIPT_LEXER_TOKENIZER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SLT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SLT_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: rtl/slt_pkg.sv
`timescale 1ns / 1ps
package slt_pkg;
  localparam int unsigned KIND_BITS = 6;
  localparam int unsigned FIELD_BITS = 24;
  localparam logic [KIND_BITS-1:0] K_EOF = 6'd0;
  localparam logic [KIND_BITS-1:0] K_BAD = 6'd1;
  localparam logic [KIND_BITS-1:0] K_UNTERM = 6'd2;
  localparam logic [KIND_BITS-1:0] K_LPAREN = 6'd3;
  localparam logic [KIND_BITS-1:0] K_RPAREN = 6'd4;
  localparam logic [KIND_BITS-1:0] K_LBRACE = 6'd5;
  localparam logic [KIND_BITS-1:0] K_RBRACE = 6'd6;
  localparam logic [KIND_BITS-1:0] K_SEMI = 6'd7;
  localparam logic [KIND_BITS-1:0] K_COMMA = 6'd8;
  localparam logic [KIND_BITS-1:0] K_DOT = 6'd9;
  localparam logic [KIND_BITS-1:0] K_MINUS = 6'd10;
  localparam logic [KIND_BITS-1:0] K_PLUS = 6'd11;
  localparam logic [KIND_BITS-1:0] K_SLASH = 6'd12;
  localparam logic [KIND_BITS-1:0] K_STAR = 6'd13;
  localparam logic [KIND_BITS-1:0] K_BANG = 6'd14;
  localparam logic [KIND_BITS-1:0] K_EQUAL = 6'd16;
  localparam logic [KIND_BITS-1:0] K_LESS = 6'd18;
  localparam logic [KIND_BITS-1:0] K_GREATER = 6'd20;
  localparam logic [KIND_BITS-1:0] K_STRING = 6'd22;
  localparam logic [KIND_BITS-1:0] K_NUMBER = 6'd23;
  localparam logic [KIND_BITS-1:0] K_IDENT = 6'd24;

  // One token as it leaves the front part; up to three per source byte.
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] length;
    logic [FIELD_BITS-1:0] line;
  } token_t;

  // Bundle of up to three tokens produced by one source byte.
  typedef struct packed {
    logic [1:0] count;
    token_t t0;
    token_t t1;
    token_t t2;
  } bundle_t;

  // Keyword lookup on up to six identifier bytes, held in an eight-byte word (zero padded).
  function automatic logic [KIND_BITS-1:0] keyword_kind(input logic [63:0] w,
                                                        input logic [3:0] len);
    logic [KIND_BITS-1:0] k;
    k = K_IDENT;
    unique case (len)
      4'd2: begin
        if (w[15:0] == "fi") k = 6'd32;
        else if (w[15:0] == "ro") k = 6'd34;
      end
      4'd3: begin
        if (w[23:0] == "dna") k = 6'd25;
        else if (w[23:0] == "fed") k = 6'd27;
        else if (w[23:0] == "rof") k = 6'd30;
        else if (w[23:0] == "nuf") k = 6'd31;
        else if (w[23:0] == "lin") k = 6'd33;
      end
      4'd4: begin
        if (w[31:0] == "esle") k = 6'd28;
        else if (w[31:0] == "siht") k = 6'd38;
        else if (w[31:0] == "eurt") k = 6'd39;
      end
      4'd5: begin
        if (w[39:0] == "ssalc") k = 6'd26;
        else if (w[39:0] == "eslaf") k = 6'd29;
        else if (w[39:0] == "tnirp") k = 6'd35;
        else if (w[39:0] == "elihw") k = 6'd40;
      end
      4'd6: begin
        if (w[47:0] == "tnerap") k = 6'd36;
        else if (w[47:0] == "nruter") k = 6'd37;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction
endpackage

FILE: rtl/script_lexer_tokenizer_core.sv
`timescale 1ns / 1ps
// Streaming scanner for a small scripting language. One source byte (or an end
// marker) is taken per request, and every cycle a new request can be accepted
// as long as the internal two-entry queue has room. The front part classifies
// the byte against the current lexer mode combinationally and hands the
// tokens that close (at most three) to the back part, which delivers them one
// per cycle while out_stall is low, marking the last token a request caused
// with last_of_run. A byte that closes several tokens holds the output until
// each of them has been taken, so sustained input rate is one request per cycle
// while tokens closed per byte stay at or below one and the output is not stalled.
// Keywords are matched in parallel on the first identifier bytes.
module script_lexer_tokenizer_core #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned KEYWORD_MAX_LEN = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] source_byte,
  input  logic end_of_input,
  output logic out_valid,
  input  logic out_stall,
  output logic [5:0] token_kind,
  output logic [23:0] token_start,
  output logic [23:0] token_length,
  output logic [23:0] line_number,
  output logic last_of_run
);
  import slt_pkg::*;

  // Request path into the front part and token bundles across the queue.
  logic q_push, q_full;
  bundle_t q_data;
  token_t tok;

  slt_front #(.POSITION_BITS(POSITION_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
    .clk, .rst, .in_valid, .in_stall, .source_byte, .end_of_input,
    .q_push, .q_data, .q_full
  );

  slt_back u_back (
    .clk, .rst, .q_push, .q_data, .q_full,
    .out_valid, .out_stall, .out_token(tok), .out_last(last_of_run)
  );

  // Token fields go straight to their own ports.
  assign token_kind = tok.kind;
  assign token_start = tok.start;
  assign token_length = tok.length;
  assign line_number = tok.line;
endmodule

FILE: rtl/slt_front.sv
`timescale 1ns / 1ps
`include "script_lexer_tokenizer_core_defines.svh"
module slt_front #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned KEYWORD_MAX_LEN = 6
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] source_byte,
  input  logic end_of_input,
  output logic q_push,
  output slt_pkg::bundle_t q_data,
  input  logic q_full
);
  import slt_pkg::*;

  localparam logic [3:0] M_IDLE = 4'd0, M_IDENT = 4'd1, M_NUMBER = 4'd2,
    M_NUMDOT = 4'd3, M_FRACTION = 4'd4, M_STRING = 4'd5, M_OP = 4'd6,
    M_SLASH = 4'd7, M_COMMENT = 4'd8;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0] F_MAX = {FIELD_BITS{1'b1}};
  localparam int unsigned LW = $clog2(KEYWORD_MAX_LEN + 1);

  logic [3:0] mode, mode_next;
  logic [POSITION_BITS-1:0] pos, begin_pos, begin_next;
  logic [FIELD_BITS-1:0] line_count, line_next;
  logic [7:0] prefix [KEYWORD_MAX_LEN];
  logic [7:0] pend, pend_next;
  logic pre_wr;
  logic [LW-1:0] pre_idx;

  logic accept;
  logic [7:0] c;
  logic is_alpha, is_digit, again;
  logic [POSITION_BITS-1:0] span_raw;
  logic [FIELD_BITS-1:0] span, span_m1, span_p1;
  logic [FIELD_BITS-1:0] pos24, begin24, posm1;
  logic [63:0] word;
  logic [KIND_BITS-1:0] ident_kind, op_base;
  token_t t [3];
  logic [1:0] n;

  assign accept = in_valid && !in_stall;
  assign in_stall = q_full;
  assign c = source_byte;
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  assign is_digit = c >= "0" && c <= "9";

  // Lengths and offsets are reported in 24 bits; lengths saturate.
  always_comb begin
    span_raw = (pos >= begin_pos) ? pos - begin_pos : '0;
    pos24 = FIELD_BITS'(pos);
    begin24 = FIELD_BITS'(begin_pos);
    posm1 = (pos != '0) ? FIELD_BITS'(pos - 1'b1) : '0;
    if (POSITION_BITS > FIELD_BITS && (span_raw >> FIELD_BITS) != '0) span = F_MAX;
    else span = FIELD_BITS'(span_raw);
    span_m1 = (span != '0) ? ((POSITION_BITS > FIELD_BITS && span == F_MAX
               && (span_raw >> FIELD_BITS) != '0) ? F_MAX : span - 1'b1) : '0;
    span_p1 = (span == F_MAX) ? F_MAX : span + 1'b1;
  end

  always_comb begin
    word = '0;
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) word[i*8 +: 8] = prefix[i];
    ident_kind = (span <= FIELD_BITS'(KEYWORD_MAX_LEN))
               ? keyword_kind(word, 4'(span)) : K_IDENT;
    op_base = (pend == "!") ? K_BANG : (pend == "=") ? K_EQUAL :
              (pend == "<") ? K_LESS : K_GREATER;
  end

  // Builds one token record from its fields.
  function automatic token_t mk(input logic [KIND_BITS-1:0] k,
                                input logic [FIELD_BITS-1:0] s,
                                input logic [FIELD_BITS-1:0] l,
                                input logic [FIELD_BITS-1:0] ln);
    token_t r;
    r.kind = k; r.start = s; r.length = l; r.line = ln;
    return r;
  endfunction

  always_comb begin
    mode_next = mode;
    begin_next = begin_pos;
    line_next = line_count;
    pend_next = pend;
    pre_wr = 1'b0;
    pre_idx = '0;
    again = 1'b0;
    n = 2'd0;
    for (int i = 0; i < 3; i++) t[i] = '0;
    if (end_of_input) begin
      unique case (mode)
        M_IDENT: begin t[0] = mk(ident_kind, begin24, span, line_count); n = 2'd1; end
        M_NUMBER, M_FRACTION: begin
          t[0] = mk(K_NUMBER, begin24, span, line_count); n = 2'd1;
        end
        M_NUMDOT: begin
          t[0] = mk(K_NUMBER, begin24, span_m1, line_count);
          t[1] = mk(K_DOT, posm1, 24'd1, line_count); n = 2'd2;
        end
        M_STRING: begin t[0] = mk(K_UNTERM, begin24, span, line_count); n = 2'd1; end
        M_OP: begin t[0] = mk(op_base, begin24, 24'd1, line_count); n = 2'd1; end
        M_SLASH: begin t[0] = mk(K_SLASH, begin24, 24'd1, line_count); n = 2'd1; end
        default: n = 2'd0;
      endcase
      t[n] = mk(K_EOF, pos24, '0, line_count);
      n = n + 2'd1;
      mode_next = M_IDLE;
      pend_next = '0;
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (is_alpha || is_digit) begin
            if (span < FIELD_BITS'(KEYWORD_MAX_LEN)) begin
              pre_wr = 1'b1; pre_idx = LW'(span);
            end
          end else begin
            t[0] = mk(ident_kind, begin24, span, line_count); n = 2'd1; again = 1'b1;
          end
        end
        M_NUMBER: begin
          if (c == ".") mode_next = M_NUMDOT;
          else if (!is_digit) begin
            t[0] = mk(K_NUMBER, begin24, span, line_count); n = 2'd1; again = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit) mode_next = M_FRACTION;
          else begin
            t[0] = mk(K_NUMBER, begin24, span_m1, line_count);
            t[1] = mk(K_DOT, posm1, 24'd1, line_count); n = 2'd2; again = 1'b1;
          end
        end
        M_FRACTION: begin
          if (!is_digit) begin
            t[0] = mk(K_NUMBER, begin24, span, line_count); n = 2'd1; again = 1'b1;
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            t[0] = mk(K_STRING, begin24, span_p1, line_count); n = 2'd1;
            mode_next = M_IDLE;
          end else if (c == 8'h0a && line_count != F_MAX) line_next = line_count + 1'b1;
        end
        M_OP: begin
          pend_next = '0;
          if (c == "=") begin
            t[0] = mk(op_base + 1'b1, begin24, 24'd2, line_count); n = 2'd1;
            mode_next = M_IDLE;
          end else begin
            t[0] = mk(op_base, begin24, 24'd1, line_count); n = 2'd1; again = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_next = M_COMMENT;
          else begin
            t[0] = mk(K_SLASH, begin24, 24'd1, line_count); n = 2'd1; again = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == 8'h0a) begin
            if (line_count != F_MAX) line_next = line_count + 1'b1;
            mode_next = M_IDLE;
          end
        end
        default: again = 1'b1;
      endcase
      if (again) begin
        mode_next = M_IDLE;
        begin_next = pos;
        if (c == " " || c == 8'h0d || c == 8'h09) begin
        end else if (c == 8'h0a) begin
          if (line_count != F_MAX) line_next = line_count + 1'b1;
        end else if (is_alpha) begin
          pre_wr = 1'b1; pre_idx = '0; mode_next = M_IDENT;
        end else if (is_digit) mode_next = M_NUMBER;
        else if (c == "\"") mode_next = M_STRING;
        else if (c == "!" || c == "=" || c == "<" || c == ">") begin
          pend_next = c; mode_next = M_OP;
        end else if (c == "/") mode_next = M_SLASH;
        else begin
          t[n] = mk(K_BAD, pos24, 24'd1, line_count);
          unique case (c)
            "(": t[n].kind = K_LPAREN;
            ")": t[n].kind = K_RPAREN;
            "{": t[n].kind = K_LBRACE;
            "}": t[n].kind = K_RBRACE;
            ";": t[n].kind = K_SEMI;
            ",": t[n].kind = K_COMMA;
            ".": t[n].kind = K_DOT;
            "-": t[n].kind = K_MINUS;
            "+": t[n].kind = K_PLUS;
            "*": t[n].kind = K_STAR;
            default: t[n].kind = K_BAD;
          endcase
          n = n + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pos <= '0;
      begin_pos <= '0;
      line_count <= FIELD_BITS'(1);
      pend <= '0;
    end else if (accept) begin
      mode <= mode_next;
      begin_pos <= begin_next;
      line_count <= line_next;
      pend <= pend_next;
      if (!end_of_input && pos != POS_MAX) pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !end_of_input && pre_wr) prefix[pre_idx] <= c;
  end

  assign q_push = accept && n != 2'd0;
  assign q_data = '{count: n, t0: t[0], t1: t[1], t2: t[2]};

  `SLT_ASSERT_IMP(a_eof_pushes, accept && end_of_input, q_push)
  `SLT_ASSERT_IMP(a_no_push_full, q_push, !q_full)
  `SLT_ASSERT_NEXT(a_eof_idle, accept && end_of_input, mode == M_IDLE && pend == '0)
endmodule

FILE: rtl/slt_back.sv
`timescale 1ns / 1ps
`include "script_lexer_tokenizer_core_defines.svh"
module slt_back (
  input  logic clk,
  input  logic rst,
  input  logic q_push,
  input  slt_pkg::bundle_t q_data,
  output logic q_full,
  output logic out_valid,
  input  logic out_stall,
  output slt_pkg::token_t out_token,
  output logic out_last
);
  import slt_pkg::*;

  // Two-entry bundle queue; the head is unrolled one token per cycle while out_stall is low.
  bundle_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic [1:0] sub;
  bundle_t head;
  logic pop_tok, pop_bundle;

  assign head = slot[rd_ptr];
  assign out_valid = fill != 2'd0;
  assign q_full = fill == 2'd2;
  assign pop_tok = out_valid && !out_stall;
  assign out_last = (sub + 2'd1) == head.count;
  assign pop_bundle = pop_tok && out_last;

  always_comb begin
    unique case (sub)
      2'd0: out_token = head.t0;
      2'd1: out_token = head.t1;
      default: out_token = head.t2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
      sub <= 2'd0;
    end else begin
      if (q_push) wr_ptr <= ~wr_ptr;
      if (pop_bundle) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, q_push} - {1'b0, pop_bundle};
      if (pop_bundle) sub <= 2'd0;
      else if (pop_tok) sub <= sub + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) slot[wr_ptr] <= q_data;
  end

  `SLT_ASSERT_IMP(a_fill_range, 1'b1, fill != 2'd3)
  `SLT_ASSERT_IMP(a_sub_range, out_valid, sub < head.count)
  `SLT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_token))
endmodule

FILE: tb/script_lexer_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the streaming script lexer. Every accepted request
// is run through a behavioral scanner model kept here, and the tokens it
// predicts are queued. Each token the block delivers is compared against the
// oldest queued prediction, field by field.
module script_lexer_tokenizer_core_tb;
  import slt_pkg::*;

  // Scanner modes of the local model.
  typedef enum logic [3:0] {
    LM_IDLE, LM_IDENT, LM_NUMBER, LM_NUMDOT, LM_FRACTION,
    LM_STRING, LM_OP, LM_SLASH, LM_COMMENT
  } lex_mode_e;

  // Token kinds that the package leaves unnamed.
  localparam logic [5:0] K_BANG_EQ = 6'd15;
  localparam logic [5:0] K_EQ_EQ = 6'd17;
  localparam logic [5:0] K_LESS_EQ = 6'd19;
  localparam logic [5:0] K_GREATER_EQ = 6'd21;
  localparam logic [5:0] K_AND = 6'd25;
  localparam logic [5:0] K_CLASS = 6'd26;
  localparam logic [5:0] K_DEF = 6'd27;
  localparam logic [5:0] K_ELSE = 6'd28;
  localparam logic [5:0] K_FALSE = 6'd29;
  localparam logic [5:0] K_FOR = 6'd30;
  localparam logic [5:0] K_FUN = 6'd31;
  localparam logic [5:0] K_IF = 6'd32;
  localparam logic [5:0] K_NIL = 6'd33;
  localparam logic [5:0] K_OR = 6'd34;
  localparam logic [5:0] K_PRINT = 6'd35;
  localparam logic [5:0] K_PARENT = 6'd36;
  localparam logic [5:0] K_RETURN = 6'd37;
  localparam logic [5:0] K_THIS = 6'd38;
  localparam logic [5:0] K_TRUE = 6'd39;
  localparam logic [5:0] K_WHILE = 6'd40;
  localparam logic [23:0] SAT24 = 24'hFFFFFF;
  localparam int IDLE_PCT = 27;

  typedef struct packed {
    logic [5:0] kind;
    logic [23:0] start;
    logic [23:0] length;
    logic [23:0] line;
    logic last;
  } token_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] source_byte = 8'd0;
  logic end_of_input = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] token_kind;
  logic [23:0] token_start;
  logic [23:0] token_length;
  logic [23:0] line_number;
  logic last_of_run;

  script_lexer_tokenizer_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .source_byte(source_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .token_kind(token_kind), .token_start(token_start),
    .token_length(token_length), .line_number(line_number),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // Model state of the scanner.
  lex_mode_e scan_mode;
  logic [23:0] scan_pos;
  logic [23:0] scan_begin;
  logic [23:0] scan_line;
  logic [7:0] scan_prefix [6];
  logic [7:0] scan_pending;

  token_rec_t expected_tokens[$];
  token_rec_t step_tokens[$];
  int error_count = 0;
  bit idle_enable = 1'b1;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void push_token(input logic [5:0] kind, input logic [23:0] start,
                                     input logic [23:0] length);
    token_rec_t t;
    t.kind = kind;
    t.start = start;
    t.length = length;
    t.line = scan_line;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void bump_line();
    if (scan_line != SAT24) scan_line++;
  endfunction

  function automatic logic [23:0] token_span();
    return scan_pos >= scan_begin ? scan_pos - scan_begin : 24'd0;
  endfunction

  // Keyword match on the stored identifier prefix.
  function automatic logic [5:0] word_kind(input logic [23:0] len);
    string w;
    w = "";
    if (len > 6) return K_IDENT;
    for (int i = 0; i < len; i++) w = {w, string'(scan_prefix[i])};
    case (w)
      "and": return K_AND;
      "class": return K_CLASS;
      "def": return K_DEF;
      "else": return K_ELSE;
      "false": return K_FALSE;
      "for": return K_FOR;
      "fun": return K_FUN;
      "if": return K_IF;
      "nil": return K_NIL;
      "or": return K_OR;
      "print": return K_PRINT;
      "parent": return K_PARENT;
      "return": return K_RETURN;
      "this": return K_THIS;
      "true": return K_TRUE;
      "while": return K_WHILE;
      default: return K_IDENT;
    endcase
  endfunction

  function automatic logic [5:0] relop_kind(input bit two);
    logic [5:0] k;
    case (scan_pending)
      "!": k = two ? K_BANG_EQ : K_BANG;
      "=": k = two ? K_EQ_EQ : K_EQUAL;
      "<": k = two ? K_LESS_EQ : K_LESS;
      default: k = two ? K_GREATER_EQ : K_GREATER;
    endcase
    return k;
  endfunction

  // Number followed by a dot that did not start a fraction.
  function automatic void close_number_dot();
    logic [23:0] len;
    len = token_span();
    push_token(K_NUMBER, scan_begin, len > 0 ? len - 24'd1 : 24'd0);
    push_token(K_DOT, scan_pos > 0 ? scan_pos - 24'd1 : 24'd0, 24'd1);
  endfunction

  function automatic void lex_from_idle(input logic [7:0] c);
    scan_begin = scan_pos;
    if (c == " " || c == 8'h0D || c == 8'h09) return;
    if (c == 8'h0A) begin
      bump_line();
      return;
    end
    if (is_alpha(c)) begin
      scan_prefix[0] = c;
      scan_mode = LM_IDENT;
      return;
    end
    if (is_digit(c)) begin
      scan_mode = LM_NUMBER;
      return;
    end
    case (c)
      "\"": scan_mode = LM_STRING;
      "!", "=", "<", ">": begin
        scan_pending = c;
        scan_mode = LM_OP;
      end
      "/": scan_mode = LM_SLASH;
      "(": push_token(K_LPAREN, scan_pos, 24'd1);
      ")": push_token(K_RPAREN, scan_pos, 24'd1);
      "{": push_token(K_LBRACE, scan_pos, 24'd1);
      "}": push_token(K_RBRACE, scan_pos, 24'd1);
      ";": push_token(K_SEMI, scan_pos, 24'd1);
      ",": push_token(K_COMMA, scan_pos, 24'd1);
      ".": push_token(K_DOT, scan_pos, 24'd1);
      "-": push_token(K_MINUS, scan_pos, 24'd1);
      "+": push_token(K_PLUS, scan_pos, 24'd1);
      "*": push_token(K_STAR, scan_pos, 24'd1);
      default: push_token(K_BAD, scan_pos, 24'd1);
    endcase
  endfunction

  // Feeds a byte to the open token; returns 1 if it must be rescanned from idle.
  function automatic bit lex_in_mode(input logic [7:0] c);
    logic [23:0] len;
    len = token_span();
    case (scan_mode)
      LM_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (len < 6) scan_prefix[len] = c;
          return 1'b0;
        end
        push_token(word_kind(len), scan_begin, len);
      end
      LM_NUMBER: begin
        if (is_digit(c)) return 1'b0;
        if (c == ".") begin
          scan_mode = LM_NUMDOT;
          return 1'b0;
        end
        push_token(K_NUMBER, scan_begin, len);
      end
      LM_NUMDOT: begin
        if (is_digit(c)) begin
          scan_mode = LM_FRACTION;
          return 1'b0;
        end
        close_number_dot();
      end
      LM_FRACTION: begin
        if (is_digit(c)) return 1'b0;
        push_token(K_NUMBER, scan_begin, len);
      end
      LM_STRING: begin
        if (c == "\"") begin
          push_token(K_STRING, scan_begin, len == SAT24 ? SAT24 : len + 24'd1);
          scan_mode = LM_IDLE;
        end else if (c == 8'h0A) begin
          bump_line();
        end
        return 1'b0;
      end
      LM_OP: begin
        if (c == "=") begin
          push_token(relop_kind(1'b1), scan_begin, 24'd2);
          scan_mode = LM_IDLE;
          scan_pending = 8'd0;
          return 1'b0;
        end
        push_token(relop_kind(1'b0), scan_begin, 24'd1);
        scan_pending = 8'd0;
      end
      LM_SLASH: begin
        if (c == "/") begin
          scan_mode = LM_COMMENT;
          return 1'b0;
        end
        push_token(K_SLASH, scan_begin, 24'd1);
      end
      LM_COMMENT: begin
        if (c == 8'h0A) begin
          bump_line();
          scan_mode = LM_IDLE;
        end
        return 1'b0;
      end
      default: ;
    endcase
    scan_mode = LM_IDLE;
    return 1'b1;
  endfunction

  // Predicts the tokens of one accepted request and queues them.
  function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
    logic [23:0] len;
    step_tokens.delete();
    if (eoi) begin
      len = token_span();
      case (scan_mode)
        LM_IDENT: push_token(word_kind(len), scan_begin, len);
        LM_NUMBER, LM_FRACTION: push_token(K_NUMBER, scan_begin, len);
        LM_NUMDOT: close_number_dot();
        LM_STRING: push_token(K_UNTERM, scan_begin, len);
        LM_OP: push_token(relop_kind(1'b0), scan_begin, 24'd1);
        LM_SLASH: push_token(K_SLASH, scan_begin, 24'd1);
        default: ;
      endcase
      scan_mode = LM_IDLE;
      scan_pending = 8'd0;
      push_token(K_EOF, scan_pos, 24'd0);
    end else begin
      if (lex_in_mode(c)) lex_from_idle(c);
      if (scan_pos != SAT24) scan_pos++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // Offers one request and holds it until the block takes it. Idle gaps are
  // inserted at random before the request when enabled; valid stays high into the next
  // request when no gap follows.
  task automatic send_request(input logic [7:0] c, input logic eoi);
    while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      source_byte <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    source_byte <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(c, eoi);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  // Output side: random stall at the falling edge, compare at the rising edge.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= idle_enable && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    token_rec_t exp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d", token_kind));
      end else begin
        exp = expected_tokens.pop_front();
        if (token_kind !== exp.kind)
          report_mismatch($sformatf("kind %0d, want %0d", token_kind, exp.kind));
        if (token_start !== exp.start)
          report_mismatch($sformatf("start %0d, want %0d", token_start, exp.start));
        if (token_length !== exp.length)
          report_mismatch($sformatf("length %0d, want %0d", token_length, exp.length));
        if (line_number !== exp.line)
          report_mismatch($sformatf("line %0d, want %0d", line_number, exp.line));
        if (last_of_run !== exp.last)
          report_mismatch($sformatf("last %0b, want %0b", last_of_run, exp.last));
      end
    end
  end

  // Every operator, punctuation mark and keyword, plus some identifiers.
  task automatic test_punctuation_and_keywords();
    send_text("(){};,.-+*/ ! != = == < <= > >= ");
    send_text("and class def else false for fun if nil or print parent return ");
    send_text("this true while parents _x9 A ");
  endtask

  // Number forms, a number closed by a dot, comments, strings across lines.
  task automatic test_literals_and_comments();
    send_text("12 3.75 12.x 7.");
    send_request(8'h0A, 1'b0);
    send_text("// note\n\"two\nlines\" 4//");
    send_request(8'd0, 1'b1);
  endtask

  // Odd bytes, then flushes of open string, identifier, number-dot, operator, slash and idle modes at the end marker.
  task automatic test_end_flushes();
    send_request(8'd0, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h80, 1'b0);
    send_text("@#");
    send_text("\"open");
    send_request(8'd0, 1'b1);
    send_text("retur");
    send_request(8'd0, 1'b1);
    send_text("9.");
    send_request(8'd0, 1'b1);
    send_text("<");
    send_request(8'd0, 1'b1);
    send_text("/");
    send_request(8'd0, 1'b1);
    send_request(8'd0, 1'b1);
  endtask

  // Random program-like text with some noise bytes and end markers mixed in.
  task automatic test_random_source(input int count);
    string frags[] = '{"print", "parent", "while", "x1", "foo_bar", "42", "3.14",
                       "7.", "\"s t\"", "==", "!=", "<=", ">", "(", ")", "{", "}",
                       ";", ",", "+", "-", "*", "/", "// c\n", "\n", " ", "\t",
                       "return", "nil", "\"a\nb\""};
    string frag;
    int sent;
    sent = 0;
    while (sent < count) begin
      if (sent > count / 3 && sent < count / 2) idle_enable = 1'b0;
      else idle_enable = 1'b1;
      if ($urandom_range(99) < 12) begin
        send_request(8'($urandom), 1'b0);
        sent++;
      end else if ($urandom_range(99) < 3) begin
        send_request(8'($urandom), 1'b1);
        sent++;
      end else begin
        frag = frags[$urandom_range(frags.size() - 1)];
        send_text(frag);
        sent += frag.len();
        if ($urandom_range(1)) begin
          send_request(" ", 1'b0);
          sent++;
        end
      end
    end
    idle_enable = 1'b1;
    send_request(8'd0, 1'b1);
  endtask

  initial begin
    int waited;
    scan_mode = LM_IDLE;
    scan_pos = 24'd0;
    scan_begin = 24'd0;
    scan_line = 24'd1;
    scan_pending = 8'd0;
    foreach (scan_prefix[i]) scan_prefix[i] = 8'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_punctuation_and_keywords();
    test_literals_and_comments();
    test_end_flushes();
    test_random_source(220);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_tokens.size() > 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Generous ceiling well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
